// ===== rtl/core/nvs_pkg.sv =====
// ----------------------------------------------------------------------------
// nvs_pkg
// Shared types and constants for the nested value skip scanner: byte
// classes, scan modes, result status codes and queue sizing.
// ----------------------------------------------------------------------------
package nvs_pkg;

   // Default nesting limit; the 8-bit depth caps it at 255 in any case
   localparam int unsigned MAX_DEPTH_DEF = 255;

   // Character codes the scanner reacts to
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Byte class, worked out once by the front part
   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_BSLASH,
      CLS_CTRL,
      CLS_APOS,
      CLS_DQUOTE,
      CLS_LBRACE,
      CLS_RBRACE,
      CLS_COMMA
   } cls_type;

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_STR,
      MODE_ESC
   } mode_type;

   typedef enum logic [2:0] {
      ST_CONT,
      ST_END_BRACE,
      ST_END_COMMA,
      ST_BAD_CHAR,
      ST_OVERFLOW
   } status_type;

   // One queued item
   typedef struct packed {
      cls_type cls;
   } item_type;

   // Front to queue
   typedef struct packed {
      logic     push;
      item_type item;
   } q_push_type;

   // Queue occupancy flags
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/core/nvs_req_if.sv =====
// ----------------------------------------------------------------------------
// nvs_req_if
// Input byte channel: valid/ready handshake carrying one text byte.
// ----------------------------------------------------------------------------
interface nvs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/core/nvs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nvs_rsp_if
// Result channel: valid/ready handshake carrying status, consumed flag
// and the nesting depth after the byte.
// ----------------------------------------------------------------------------
interface nvs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] scan_status;
   logic       byte_consumed;
   logic [7:0] depth_now;

   modport source (output valid, output scan_status, output byte_consumed,
                   output depth_now, input ready);
   modport sink   (input valid, input scan_status, input byte_consumed,
                   input depth_now, output ready);
endinterface

// ===== rtl/core/nvs_front.sv =====
// ----------------------------------------------------------------------------
// nvs_front
// Front part: accepts input bytes while the queue has room and sorts each
// byte into the class the scanner state machine acts on.
// ----------------------------------------------------------------------------
module nvs_front (
   nvs_req_if.sink               req_if,
   input  nvs_pkg::q_status_type q_status,
   output nvs_pkg::q_push_type   q_push
);
   import nvs_pkg::*;

   cls_type cls;

   // Byte classification; control bytes only matter inside strings
   always_comb begin
      if (req_if.in_byte == CH_BSLASH) begin
         cls = CLS_BSLASH;
      end else if (req_if.in_byte < CH_SPACE) begin
         cls = CLS_CTRL;
      end else if (req_if.in_byte == CH_APOS) begin
         cls = CLS_APOS;
      end else if (req_if.in_byte == CH_DQUOTE) begin
         cls = CLS_DQUOTE;
      end else if (req_if.in_byte == CH_LBRACE) begin
         cls = CLS_LBRACE;
      end else if (req_if.in_byte == CH_RBRACE) begin
         cls = CLS_RBRACE;
      end else if (req_if.in_byte == CH_COMMA) begin
         cls = CLS_COMMA;
      end else begin
         cls = CLS_OTHER;
      end
   end

   // Transfer into the queue
   assign req_if.ready      = ~q_status.full;
   assign q_push.push       = req_if.valid & ~q_status.full;
   assign q_push.item.cls   = cls;

endmodule

// ===== rtl/core/nvs_queue.sv =====
// ----------------------------------------------------------------------------
// nvs_queue
// Short register queue between front and back; push and pop may happen
// in the same cycle.
// ----------------------------------------------------------------------------
module nvs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  nvs_pkg::q_push_type   q_push,
   input  logic                  pop,
   output nvs_pkg::item_type     head,
   output nvs_pkg::q_status_type q_status
);
   import nvs_pkg::*;

   item_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign q_status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = q_push.push & ~q_status.full;
   assign do_pop         = pop & ~q_status.empty;
   assign head           = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_push.item;
      end
   end

endmodule

// ===== rtl/core/nvs_back.sv =====
// ----------------------------------------------------------------------------
// nvs_back
// Back part: scanner state machine (mode, quote kind, nesting depth) and
// the registered result stage.
// ----------------------------------------------------------------------------
module nvs_back #(
   parameter int unsigned MAX_DEPTH = nvs_pkg::MAX_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nvs_pkg::item_type     head,
   input  nvs_pkg::q_status_type q_status,
   output logic                  pop,
   nvs_rsp_if.source             rsp_if
);
   import nvs_pkg::*;

   // Nesting limit clipped to what the 8-bit depth can hold
   localparam logic [7:0] DepthLimit = (MAX_DEPTH > 255) ? 8'd255 : 8'(MAX_DEPTH);

   mode_type   mode_ff, mode_in;
   logic       quote_ff, quote_in;
   logic [7:0] depth_ff, depth_in;

   logic       out_valid_ff, out_valid_in;
   status_type status_ff, status_in;
   logic       consumed_ff;
   logic [7:0] depth_out_ff;

   logic       take;
   cls_type    term_cls;

   // A new item is taken whenever the result register is free or drains
   assign take = ~q_status.empty & (~out_valid_ff | rsp_if.ready);
   assign pop  = take;
   assign term_cls = quote_ff ? CLS_DQUOTE : CLS_APOS;

   // Next state
   always_comb begin
      mode_in   = mode_ff;
      quote_in  = quote_ff;
      depth_in  = depth_ff;
      status_in = ST_CONT;
      unique case (mode_ff)
         MODE_ESC: begin
            mode_in = MODE_STR;
         end
         MODE_STR: begin
            if (head.cls == CLS_BSLASH) begin
               mode_in = MODE_ESC;
            end else if (head.cls == CLS_CTRL) begin
               status_in = ST_BAD_CHAR;
            end else if (head.cls == term_cls) begin
               mode_in = MODE_PLAIN;
            end
         end
         default: begin
            mode_in = MODE_PLAIN;
            case (head.cls)
               CLS_APOS: begin
                  mode_in  = MODE_STR;
                  quote_in = 1'b0;
               end
               CLS_DQUOTE: begin
                  mode_in  = MODE_STR;
                  quote_in = 1'b1;
               end
               CLS_LBRACE: begin
                  if (depth_ff >= DepthLimit) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     depth_in = depth_ff + 8'd1;
                  end
               end
               CLS_RBRACE: begin
                  if (depth_ff == '0) begin
                     status_in = ST_END_BRACE;
                  end else begin
                     depth_in = depth_ff - 8'd1;
                  end
               end
               CLS_COMMA: begin
                  if (depth_ff == '0) begin
                     status_in = ST_END_COMMA;
                  end
               end
               default: begin
               end
            endcase
         end
      endcase
      // Value end or error: back to the reset state
      if (status_in != ST_CONT) begin
         mode_in  = MODE_PLAIN;
         quote_in = 1'b0;
         depth_in = '0;
      end
      out_valid_in = take | (out_valid_ff & ~rsp_if.ready);
   end

   // State and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PLAIN;
         quote_ff     <= 1'b0;
         depth_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            mode_ff  <= mode_in;
            quote_ff <= quote_in;
            depth_ff <= depth_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (take) begin
         status_ff    <= status_in;
         consumed_ff  <= (status_in == ST_CONT);
         depth_out_ff <= depth_in;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.scan_status   = status_ff;
   assign rsp_if.byte_consumed = consumed_ff;
   assign rsp_if.depth_now     = depth_out_ff;

endmodule

// ===== rtl/core/nested_value_skip_scanner.sv =====
// ----------------------------------------------------------------------------
// nested_value_skip_scanner
// Scans past one value in ASN.1 value notation, one text byte per transfer.
//
// Usage:
//   req_if carries one text byte per transfer (in_byte). rsp_if returns
//   exactly one result per byte: scan_status (continuing, ended at close
//   brace, ended at comma, bad string byte, nesting overflow),
//   byte_consumed and depth_now, the nesting depth after the byte.
//   A byte that ends the value or is rejected is reported not consumed
//   and the scanner returns to its reset state for the next value.
//   One byte per cycle is sustained while rsp_if.ready stays high; the
//   rate is set by the mode/depth update in the back part.
//   A two-entry queue sits between the classifying front and the state
//   machine; the result register takes the next byte while the current
//   result drains. When the receiver stalls, the result holds, the queue
//   fills and req_if.ready drops.
//   Reset (synchronous) clears depth, mode, queue and result valid.
// ----------------------------------------------------------------------------
module nested_value_skip_scanner #(
   parameter int unsigned MAX_DEPTH = nvs_pkg::MAX_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   nvs_req_if.sink   req_if,
   nvs_rsp_if.source rsp_if
);
   import nvs_pkg::*;

   q_push_type   q_push;
   q_status_type q_status;
   item_type     head;
   logic         pop;

   // Accept and classify
   nvs_front u_front (
      .req_if   (req_if),
      .q_status (q_status),
      .q_push   (q_push)
   );

   // Decoupling queue
   nvs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   // Scanner state and result stage
   nvs_back #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule

// ===== tb/nested_value_skip_scanner_test.sv =====
// ----------------------------------------------------------------------------
// nested_value_skip_scanner_test
// Self-checking bench for the nested value skip scanner. Text bytes go in
// over the request channel. Each accepted byte runs through a behavioural
// model of the scanner, which predicts status, consumed flag and depth.
// Results coming back are checked in order against those predictions.
// Directed tests cover value ends, nesting, strings with escapes, bad
// string bytes and depth overflow. Random tests then send well-formed
// values with random content, mixed with noise, under three idling
// patterns.
// ----------------------------------------------------------------------------
module nested_value_skip_scanner_test;
   import nvs_pkg::*;

   localparam int unsigned NEST_LIMIT = MAX_DEPTH_DEF;
   // The depth register is 8 bits wide, so the limit saturates at 255
   localparam int unsigned NEST_CAP   = (NEST_LIMIT > 255) ? 255 : NEST_LIMIT;
   localparam int RUN_LIMIT    = 400000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct {
      status_type status;
      logic       consumed;
      logic [7:0] depth;
   } scan_result_type;

   logic clock;
   logic reset;

   nvs_req_if req_chan ();
   nvs_rsp_if rsp_chan ();

   nested_value_skip_scanner #(
      .MAX_DEPTH(NEST_LIMIT)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_chan),
      .rsp_if(rsp_chan)
   );

   // Model state of the scanner
   logic [7:0] nest_depth_q;
   mode_type   scan_mode_q;
   logic       in_dquote_q;

   scan_result_type pending_scans[$];
   scan_result_type head_scan;

   int send_gap_pct;
   int rsp_stall_pct;
   int bytes_sent;
   int results_seen   = 0;
   int mismatches     = 0;
   int cycle_count    = 0;
   int deepest_nest;
   int status_seen[5] = '{default: 0};

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle budget
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_scans.size());
         $display("nested_value_skip_scanner_test: done, errors");
         $finish;
      end
   end

   // Receiver back-pressure, changed at the falling edge
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Behavioural scanner: advance the model by one byte, return its result
   function automatic scan_result_type scan_byte(input logic [7:0] b);
      scan_result_type res;
      status_type      st;
      logic [7:0]      term;
      st = ST_CONT;
      case (scan_mode_q)
         MODE_ESC: begin
            // escaped byte is always string content
            scan_mode_q = MODE_STR;
         end
         MODE_STR: begin
            term = in_dquote_q ? CH_DQUOTE : CH_APOS;
            if (b == CH_BSLASH) begin
               scan_mode_q = MODE_ESC;
            end else if (b < CH_SPACE) begin
               st = ST_BAD_CHAR;
            end else if (b == term) begin
               scan_mode_q = MODE_PLAIN;
            end
         end
         default: begin
            // plain scanning; the unused mode code behaves the same
            scan_mode_q = MODE_PLAIN;
            if (b == CH_APOS || b == CH_DQUOTE) begin
               scan_mode_q = MODE_STR;
               in_dquote_q = (b == CH_DQUOTE);
            end else if (b == CH_LBRACE) begin
               if (nest_depth_q >= NEST_CAP) st = ST_OVERFLOW;
               else nest_depth_q = nest_depth_q + 8'd1;
            end else if (b == CH_RBRACE) begin
               if (nest_depth_q == 8'd0) st = ST_END_BRACE;
               else nest_depth_q = nest_depth_q - 8'd1;
            end else if (b == CH_COMMA && nest_depth_q == 8'd0) begin
               st = ST_END_COMMA;
            end
         end
      endcase
      // value end or error: back to the idle state
      if (st != ST_CONT) begin
         nest_depth_q = 8'd0;
         scan_mode_q  = MODE_PLAIN;
         in_dquote_q  = 1'b0;
      end
      if (int'(nest_depth_q) > deepest_nest) deepest_nest = int'(nest_depth_q);
      res.status   = st;
      res.consumed = (st == ST_CONT);
      res.depth    = nest_depth_q;
      return res;
   endfunction

   // Result checker: every transfer on the result channel against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (pending_scans.size() == 0) begin
            $error("result with nothing expected: status %0d consumed %0d depth %0d",
                   rsp_chan.scan_status, rsp_chan.byte_consumed, rsp_chan.depth_now);
            mismatches++;
         end else begin
            head_scan = pending_scans.pop_front();
            if (rsp_chan.scan_status < 5) status_seen[rsp_chan.scan_status]++;
            if (rsp_chan.scan_status !== head_scan.status) begin
               $error("scan_status: expected %0d, got %0d",
                      head_scan.status, rsp_chan.scan_status);
               mismatches++;
            end
            if (rsp_chan.byte_consumed !== head_scan.consumed) begin
               $error("byte_consumed: expected %0d, got %0d",
                      head_scan.consumed, rsp_chan.byte_consumed);
               mismatches++;
            end
            if (rsp_chan.depth_now !== head_scan.depth) begin
               $error("depth_now: expected %0d, got %0d",
                      head_scan.depth, rsp_chan.depth_now);
               mismatches++;
            end
         end
      end
   end

   // One byte transfer; entered and left at a falling edge
   task automatic push_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_scans.push_back(scan_byte(b));
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   // Commas and close braces at depth zero, and bytes that are plain content
   task automatic test_plain_ends();
      push_byte(8'h00);
      push_byte(8'hFF);
      send_text("a1 ");
      push_byte(CH_COMMA);
      send_text("TRUE");
      push_byte(CH_RBRACE);
   endtask

   // Inside braces a comma is content and a close brace only lowers the depth; the last one ends the value
   task automatic test_nesting();
      send_text("{x{");
      push_byte(CH_COMMA);
      send_text("}}");
      push_byte(CH_RBRACE);
   endtask

   // Both quote kinds, the other quote as content, escapes and high bytes
   task automatic test_strings();
      push_byte(CH_APOS);
      push_byte(CH_DQUOTE);
      push_byte(8'h80);
      push_byte(CH_SPACE);
      push_byte(CH_BSLASH);
      push_byte(CH_APOS);
      push_byte(CH_BSLASH);
      push_byte(8'h01);
      push_byte(CH_APOS);
      push_byte(CH_DQUOTE);
      push_byte(CH_LBRACE);
      push_byte(CH_COMMA);
      push_byte(CH_APOS);
      push_byte(CH_BSLASH);
      push_byte(CH_BSLASH);
      push_byte(CH_DQUOTE);
      push_byte(CH_COMMA);
   endtask

   // Control bytes inside strings abort the value and clear the depth
   task automatic test_bad_string_bytes();
      push_byte(CH_LBRACE);
      push_byte(CH_DQUOTE);
      push_byte(8'h1F);
      push_byte(CH_APOS);
      push_byte(8'h00);
      push_byte(CH_RBRACE);
   endtask

   // Fill the nesting to its limit, then one brace too many
   task automatic test_nesting_overflow();
      repeat (NEST_CAP) push_byte(CH_LBRACE);
      push_byte(CH_LBRACE);
      push_byte(CH_RBRACE);
   endtask

   // Quoted string with random content, now and then broken by a control byte
   task automatic send_string();
      logic [7:0] quote;
      logic [7:0] c;
      int         n;
      quote = $urandom_range(1) ? CH_DQUOTE : CH_APOS;
      push_byte(quote);
      n = $urandom_range(8);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: begin
               push_byte(CH_BSLASH);
               push_byte(8'($urandom_range(255)));
            end
            1: push_byte((quote == CH_DQUOTE) ? CH_APOS : CH_DQUOTE);
            2: push_byte(8'($urandom_range(128, 255)));
            default: begin
               c = 8'($urandom_range(32, 126));
               if (c == quote || c == CH_BSLASH) c = "z";
               push_byte(c);
            end
         endcase
      end
      if ($urandom_range(19) == 0) begin
         push_byte(8'($urandom_range(31)));
      end else begin
         push_byte(quote);
      end
   endtask

   // One value with random content, ended by a comma or a brace; its strings may hold a bad byte
   task automatic send_value();
      int         lvl;
      int         max_lvl;
      int         tokens;
      logic [7:0] c;
      lvl     = 0;
      max_lvl = ($urandom_range(7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
      tokens  = $urandom_range(1, 12);
      for (int k = 0; k < tokens; k++) begin
         case ($urandom_range(9))
            0, 1: begin
               if (lvl < max_lvl) begin
                  push_byte(CH_LBRACE);
                  lvl++;
               end
            end
            2: begin
               if (lvl > 0) begin
                  push_byte(CH_RBRACE);
                  lvl--;
               end
            end
            3: if (lvl > 0) push_byte(CH_COMMA);
            4, 5: send_string();
            default: begin
               repeat ($urandom_range(1, 4)) begin
                  c = 8'($urandom_range(32, 126));
                  if (c == CH_APOS || c == CH_DQUOTE || c == CH_LBRACE ||
                      c == CH_RBRACE || c == CH_COMMA) c = "a";
                  push_byte(c);
               end
            end
         endcase
      end
      while (lvl > 0) begin
         push_byte(CH_RBRACE);
         lvl--;
      end
      push_byte($urandom_range(1) ? CH_COMMA : CH_RBRACE);
   endtask

   // Raw bytes, biased toward the ones the scanner reacts to
   task automatic send_noise();
      logic [7:0] specials[8];
      specials = '{CH_BSLASH, CH_SPACE, CH_LBRACE, CH_RBRACE,
                    CH_COMMA, CH_APOS, CH_DQUOTE, 8'h1F};
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(1)) push_byte(specials[3'($urandom_range(7))]);
         else push_byte(8'($urandom_range(255)));
      end
   endtask

   // Mostly well-formed values, the rest noise
   task automatic test_random_values(input int gap_pct, input int stall_pct,
                                     input int count);
      int start;
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      start         = bytes_sent;
      while (bytes_sent - start < count) begin
         if ($urandom_range(9) < 8) send_value();
         else send_noise();
      end
   endtask

   // Main sequence
   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = 8'h00;
      nest_depth_q     = 8'd0;
      scan_mode_q      = MODE_PLAIN;
      in_dquote_q      = 1'b0;
      send_gap_pct     = 10;
      rsp_stall_pct    = 88;
      bytes_sent       = 0;
      deepest_nest     = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_plain_ends();
      test_nesting();
      test_strings();
      test_bad_string_bytes();
      test_nesting_overflow();
      test_random_values(10, 88, 50);
      test_random_values(88, 10, 50);
      test_random_values(0, 0, 50);

      req_chan.valid <= 1'b0;
      while (pending_scans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d bytes, %0d results: %0d continuing, %0d brace ends, %0d comma ends",
               bytes_sent, results_seen, status_seen[ST_CONT],
               status_seen[ST_END_BRACE], status_seen[ST_END_COMMA]);
      $display("%0d bad string bytes, %0d overflows, deepest nesting %0d",
               status_seen[ST_BAD_CHAR], status_seen[ST_OVERFLOW], deepest_nest);
      if (mismatches == 0 && pending_scans.size() == 0) begin
         $display("nested_value_skip_scanner_test: done, clean");
      end else begin
         $display("nested_value_skip_scanner_test: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/nvs_pkg.sv
rtl/core/nvs_req_if.sv
rtl/core/nvs_rsp_if.sv
rtl/core/nvs_front.sv
rtl/core/nvs_queue.sv
rtl/core/nvs_back.sv
rtl/core/nested_value_skip_scanner.sv
tb/nested_value_skip_scanner_test.sv
